// ----- design/resonant_filter_with_release_envelope_core_defines.svh -----
// Assertion macros shared by the resonant filter core.
`ifndef RESONANT_FILTER_WITH_RELEASE_ENVELOPE_CORE_DEFINES_SVH
`define RESONANT_FILTER_WITH_RELEASE_ENVELOPE_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset
`define RFRE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset
`define RFRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rfre_pkg.sv -----
`timescale 1ns / 1ps

package rfre_pkg;

   // Field widths
   localparam int SAMPLE_W   = 8;
   localparam int COEF_W     = 16;
   localparam int LEN_W      = 15;
   localparam int ACC_W      = 26;
   localparam int MAC_PROD_W = COEF_W + SAMPLE_W;
   localparam int MAG_W      = 8;
   localparam int PROD_W     = MAG_W + LEN_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int MAC_TERMS  = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN      = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_FIRST  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_SECOND = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DECAY_LENGTH    = 2'd3;

   // Operand select for the multiply-accumulate pass
   localparam logic [1:0] MAC_SEL_GAIN = 2'd0;
   localparam logic [1:0] MAC_SEL_FB1  = 2'd1;
   localparam logic [1:0] MAC_SEL_FB2  = 2'd2;

   // Saturation bounds of the accumulator
   localparam logic signed [ACC_W-1:0] ACC_MAX = 26'sd32767;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -26'sd32768;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sd127;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -8'sd128;

   typedef struct packed {
      logic signed [COEF_W-1:0] input_gain;
      logic signed [COEF_W-1:0] feedback_first;
      logic signed [COEF_W-1:0] feedback_second;
      logic [LEN_W-1:0]         decay_length;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       mac_en;
      logic       mac_first;
      logic [1:0] mac_sel;
      logic       sat_en;
      logic       env_en;
      logic       div_step;
      logic       fix_en;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic scale;
   } stat_type;

endpackage

// ----- design/rfre_csr.sv -----
`timescale 1ns / 1ps

module rfre_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rfre_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rfre_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rfre_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output rfre_pkg::cfg_type                  cfg
);
   import rfre_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INPUT_GAIN:      cfg_in.input_gain      = pwdata[COEF_W-1:0];
            REG_FEEDBACK_FIRST:  cfg_in.feedback_first  = pwdata[COEF_W-1:0];
            REG_FEEDBACK_SECOND: cfg_in.feedback_second = pwdata[COEF_W-1:0];
            REG_DECAY_LENGTH:    cfg_in.decay_length    = pwdata[LEN_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_INPUT_GAIN:      prdata = CSR_DATA_W'(unsigned'(cfg_ff.input_gain));
         REG_FEEDBACK_FIRST:  prdata = CSR_DATA_W'(unsigned'(cfg_ff.feedback_first));
         REG_FEEDBACK_SECOND: prdata = CSR_DATA_W'(unsigned'(cfg_ff.feedback_second));
         REG_DECAY_LENGTH:    prdata = CSR_DATA_W'(cfg_ff.decay_length);
         default:             prdata = '0;
      endcase
   end

endmodule

// ----- design/rfre_ctrl.sv -----
`timescale 1ns / 1ps
`include "resonant_filter_with_release_envelope_core_defines.svh"

module rfre_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  rfre_pkg::stat_type stat,
   output rfre_pkg::cmd_type  cmd
);
   import rfre_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAC  = 7'b0000010,
      ST_SAT  = 7'b0000100,
      ST_ENV  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_FIX  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   step_cnt_ff;
   logic [CNT_W-1:0]   step_cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one request through the datapath
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      cmd.mac_sel = step_cnt_ff[1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               step_cnt_in = '0;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac_en    = 1'b1;
            cmd.mac_first = (step_cnt_ff == '0);
            if (step_cnt_ff == CNT_W'(MAC_TERMS - 1)) begin
               step_cnt_in = '0;
               state_in    = ST_SAT;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_SAT: begin
            cmd.sat_en = 1'b1;
            state_in   = ST_ENV;
         end
         ST_ENV: begin
            cmd.env_en  = 1'b1;
            step_cnt_in = '0;
            state_in    = stat.scale ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               step_cnt_in = '0;
               state_in    = ST_FIX;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_FIX: begin
            cmd.fix_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result valid until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RFRE_ASSERT_NEXT(a_accept_starts_mac, clock, reset, req_valid && !req_stall, state_ff == ST_MAC, "accepted request did not start the filter pass")
   `RFRE_ASSERT_IMPLIES(a_out_load_free, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall, "result register overwritten while still held")
   `RFRE_ASSERT_IMPLIES(a_div_count_range, clock, reset, state_ff == ST_DIV, step_cnt_ff < CNT_W'(DIV_STEPS), "divider step count out of range")

endmodule

// ----- design/rfre_datapath.sv -----
`timescale 1ns / 1ps

module rfre_datapath #(
   parameter int MAX_DECAY = 24000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rfre_pkg::cfg_type                     cfg,
   input  rfre_pkg::cmd_type                     cmd,
   input  logic signed [rfre_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                  req_gate,
   output logic signed [rfre_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output rfre_pkg::stat_type                    stat
);
   import rfre_pkg::*;

   // Request and filter state
   logic signed [SAMPLE_W-1:0]   x_ff;
   logic                         gate_ff;
   logic signed [SAMPLE_W-1:0]   y1_ff;
   logic signed [SAMPLE_W-1:0]   y2_ff;
   logic signed [SAMPLE_W-1:0]   y_ff;
   logic signed [SAMPLE_W-1:0]   y_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic [LEN_W-1:0]             release_count_ff;
   logic [LEN_W-1:0]             release_count_in;
   logic [MAG_W-1:0]             mag_ff;
   logic                         neg_ff;
   logic [PROD_W-1:0]            dq_ff;
   logic [PROD_W-1:0]            dq_in;
   logic [LEN_W-1:0]             rem_ff;
   logic [LEN_W-1:0]             rem_in;
   logic signed [SAMPLE_W-1:0]   res_ff;
   logic signed [SAMPLE_W-1:0]   res_in;
   logic signed [SAMPLE_W-1:0]   out_ff;

   logic signed [COEF_W-1:0]     mac_coef;
   logic signed [SAMPLE_W-1:0]   mac_samp;
   logic signed [MAC_PROD_W-1:0] mac_prod;
   logic                         release_done;
   logic [PROD_W-1:0]            env_prod;
   logic [LEN_W:0]               trial;
   logic                         trial_ge;
   logic [MAG_W-1:0]             quot;

   // Pick the coefficient and sample for this term
   always_comb begin
      unique case (cmd.mac_sel)
         MAC_SEL_GAIN: begin
            mac_coef = cfg.input_gain;
            mac_samp = x_ff;
         end
         MAC_SEL_FB1: begin
            mac_coef = cfg.feedback_first;
            mac_samp = y1_ff;
         end
         MAC_SEL_FB2: begin
            mac_coef = cfg.feedback_second;
            mac_samp = y2_ff;
         end
         default: begin
            mac_coef = '0;
            mac_samp = '0;
         end
      endcase
   end

   assign mac_prod = mac_coef * mac_samp;
   assign acc_in   = (cmd.mac_first ? ACC_W'(0) : acc_ff) + ACC_W'(mac_prod);

   // Saturate to 16 bits and keep the top byte
   always_comb begin
      priority if (acc_ff > ACC_MAX) begin
         y_in = SAMPLE_MAX;
      end else if (acc_ff < ACC_MIN) begin
         y_in = SAMPLE_MIN;
      end else begin
         y_in = acc_ff[COEF_W-1:SAMPLE_W];
      end
   end

   // Envelope decision and scaled magnitude
   assign release_done = (release_count_ff >= cfg.decay_length);
   assign stat.scale   = !gate_ff && !release_done;
   assign env_prod     = PROD_W'(mag_ff) * PROD_W'(cfg.decay_length - release_count_ff);

   // One restoring division step per cycle
   assign trial    = {rem_ff, dq_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, cfg.decay_length});
   assign rem_in   = trial_ge ? LEN_W'(trial - {1'b0, cfg.decay_length}) : trial[LEN_W-1:0];
   assign dq_in    = {dq_ff[PROD_W-2:0], trial_ge};
   assign quot     = dq_ff[MAG_W-1:0];

   always_comb begin
      res_in           = res_ff;
      release_count_in = release_count_ff;
      if (cmd.env_en) begin
         priority if (gate_ff) begin
            res_in           = y_ff;
            release_count_in = '0;
         end else if (release_done) begin
            res_in = '0;
         end else begin
            release_count_in = release_count_ff + 1'b1;
         end
      end else if (cmd.fix_en) begin
         res_in = neg_ff ? signed'(MAG_W'(0) - quot) : signed'(quot);
      end
   end

   // Filter history and release count
   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff            <= '0;
         y2_ff            <= '0;
         release_count_ff <= LEN_W'(MAX_DECAY);
      end else begin
         if (cmd.sat_en) begin
            y1_ff <= y_in;
            y2_ff <= y1_ff;
         end
         release_count_ff <= release_count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_sample_in;
         gate_ff <= req_gate;
      end
      if (cmd.mac_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.sat_en) begin
         y_ff   <= y_in;
         neg_ff <= y_in[SAMPLE_W-1];
         mag_ff <= y_in[SAMPLE_W-1] ? MAG_W'(-y_in) : MAG_W'(y_in);
      end
      if (cmd.env_en) begin
         dq_ff  <= env_prod;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      res_ff <= res_in;
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

// ----- design/resonant_filter_with_release_envelope_core.sv -----
`timescale 1ns / 1ps

// Two-pole Q8.8 recursive filter followed by a linear release envelope, one
// signed 8-bit sample in and one out per request. An accepted request runs
// the three-term multiply-accumulate, which shares one 16x8 multiplier, then
// saturation and the envelope step. While the gate is low and the release
// has not run out, the 23-step bit-serial divider and a sign fix follow to
// scale the sample. The result then waits for the output register to be free,
// and no new request is taken before the block is back in idle.
// A new request is taken once the previous result sits in the output register,
// even if that result is still stalled. Coefficients and the release length sit
// behind the APB port at byte addresses 0, 4, 8 and 12. The user must see that
// they are changed only while the block is idle; the block does not enforce it.
module resonant_filter_with_release_envelope_core #(
   parameter int MAX_DECAY = 24000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rfre_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                  req_gate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rfre_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rfre_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [rfre_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [rfre_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import rfre_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // Configuration registers
   rfre_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   rfre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic
   rfre_datapath #(
      .MAX_DECAY (MAX_DECAY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .req_gate       (req_gate),
      .rsp_sample_out (rsp_sample_out),
      .stat           (stat)
   );

endmodule
